### design/spi_sra_pkg.sv
// shared constants and types for the spi slave register access block
`default_nettype none
package spi_sra_pkg;

    localparam int SETTINGS_DEPTH = 256;
    localparam int SET_AW         = $clog2(SETTINGS_DEPTH);
    localparam int VALUE_BYTES    = 4;
    localparam int VAL_W          = 8 * VALUE_BYTES;
    localparam int CNT_W          = $clog2(VALUE_BYTES + 1);
    localparam int BSEL_W         = (VALUE_BYTES > 1) ? $clog2(VALUE_BYTES) : 1;
    localparam int BYTE_W         = 8;
    localparam int CFG_IDX_W      = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_READ_OPCODE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_OPCODE = CFG_IDX_W'(1);

    // item kinds carried on the slave tuser
    localparam logic KIND_BYTE     = 1'b0;
    localparam logic KIND_DESELECT = 1'b1;

    // transfer phase
    typedef enum logic [2:0] {
        PH_CMD  = 3'b001,
        PH_ADDR = 3'b010,
        PH_DATA = 3'b100
    } t_phase;

    // request from the byte handler to the settings store
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [SET_AW-1:0] addr;
        logic [BYTE_W-1:0] wdata;
    } t_store_req;

endpackage
`default_nettype wire

### design/spi_sra_store.sv
// settings store: 8-bit synchronous memory with per-entry valid bits
`default_nettype none
module spi_sra_store (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire spi_sra_pkg::t_store_req           i_req,
    output logic [spi_sra_pkg::BYTE_W-1:0]         o_rd_data
);
    import spi_sra_pkg::*;

    logic [BYTE_W-1:0]         r_mem [SETTINGS_DEPTH];
    logic [SETTINGS_DEPTH-1:0] r_vld;
    logic [BYTE_W-1:0]         r_rd_raw;
    logic                      r_rd_vld;

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_raw <= r_mem[i_req.addr];
            r_rd_vld <= r_vld[i_req.addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_raw : '0;

endmodule
`default_nettype wire

### design/spi_slave_register_access.sv
// top level: spi slave command, address and settings register byte handler
//
// slave stream: one transaction per spi event. tuser says what it is (a byte
// shifted in from the master, or slave select going away); tdata carries the
// received byte and the live 32-bit word that a read of address zero captures.
// the first byte of a transfer is the command, the second the address. a read
// of address zero sends the captured word low byte first, one byte per further
// received byte; a read of any other address sends one byte from the settings
// store; a write stores the third byte in the settings store.
// master stream: exactly one transaction per accepted slave transaction, in
// order. tuser is tx_load (a byte is loaded for the master), tdata the byte
// (zero when nothing is loaded).
// the settings store read and the result register share the same clock edge, so
// the result is registered. throughput is one transaction per cycle; the output
// register holds a result while the master side stalls, and a new item is
// taken in the cycle the held result leaves.
// config channel: index 0 is the read opcode, 1 the write opcode, others are
// dropped; always ready. write only while no transaction is in flight.
// reset (synchronous, active low) clears the phase, the command, the address,
// the byte count, the captured word and all store valid bits, so the settings
// store reads as zero at once with no clearing pass; opcodes return to 1 and 2.
`default_nettype none
module spi_slave_register_access (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // slave stream
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [39:0]                         i_s_tdata,  // rx_byte[7:0], live_value[39:8]
    input  wire logic                                i_s_tuser,  // cmd: 0 byte, 1 deselect
    // master stream
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    output logic [7:0]                               o_m_tdata,  // tx_byte[7:0]
    output logic                                     o_m_tuser,  // tx_load
    // config write channel
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [spi_sra_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [7:0]                          i_cfg_data
);
    import spi_sra_pkg::*;

    // opcode registers
    logic [BYTE_W-1:0] r_rd_op;
    logic [BYTE_W-1:0] r_wr_op;

    // transfer state
    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_cmd,   n_cmd;
    logic [BYTE_W-1:0] r_addr,  n_addr;
    logic [CNT_W-1:0]  r_cnt,   n_cnt;
    logic [VAL_W-1:0]  r_cap,   n_cap;

    // result register
    logic              r_o_valid;
    logic              r_o_load,  n_o_load;
    logic              r_o_mem,   n_o_mem;
    logic [BYTE_W-1:0] r_o_byte,  n_o_byte;

    t_store_req        s_req;
    logic [BYTE_W-1:0] s_rd_data;
    logic              s_in_acc;
    logic              s_kind;
    logic [BYTE_W-1:0] s_rx;
    logic [31:0]       s_live;

    assign s_kind = i_s_tuser;
    assign s_rx   = i_s_tdata[BYTE_W-1:0];
    assign s_live = i_s_tdata[39:8];

    // the result register frees up in the same cycle it is taken
    assign o_s_tready = !r_o_valid || i_m_tready;
    assign s_in_acc   = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_op <= BYTE_W'(1);
            r_wr_op <= BYTE_W'(2);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_READ_OPCODE:  r_rd_op <= i_cfg_data;
                CFG_WRITE_OPCODE: r_wr_op <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-byte decode of the transfer
    always_comb begin
        n_phase  = r_phase;
        n_cmd    = r_cmd;
        n_addr   = r_addr;
        n_cnt    = r_cnt;
        n_cap    = r_cap;
        n_o_load = 1'b0;
        n_o_mem  = 1'b0;
        n_o_byte = '0;
        s_req.rd_en = 1'b0;
        s_req.wr_en = 1'b0;
        s_req.addr  = r_addr[SET_AW-1:0];
        s_req.wdata = s_rx;

        if (s_in_acc) begin
            if (s_kind == KIND_DESELECT) begin
                n_phase = PH_CMD;
                n_cmd   = '0;
                n_cnt   = '0;
            end else begin
                case (r_phase)
                    PH_CMD: begin
                        n_cmd   = s_rx;
                        n_phase = PH_ADDR;
                    end
                    PH_ADDR: begin
                        n_addr = s_rx;
                        if (r_cmd == r_rd_op) begin
                            n_o_load = 1'b1;
                            if (s_rx == '0) begin
                                // capture the live word, send its low byte now
                                n_cap    = VAL_W'(s_live);
                                n_o_byte = s_live[BYTE_W-1:0];
                                n_cnt    = CNT_W'(1);
                                n_phase  = PH_DATA;
                            end else begin
                                // single byte from the store, then back to idle
                                n_o_mem     = 1'b1;
                                s_req.rd_en = 1'b1;
                                s_req.addr  = s_rx[SET_AW-1:0];
                                n_cmd       = '0;
                                n_cnt       = '0;
                                n_phase     = PH_CMD;
                            end
                        end else begin
                            // write or unknown command: wait in data phase
                            n_phase = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        if (r_cmd == r_rd_op) begin
                            if (r_addr != '0) begin
                                n_phase = PH_CMD;
                            end else if (r_cnt < CNT_W'(VALUE_BYTES)) begin
                                n_o_load = 1'b1;
                                n_o_byte = r_cap[BYTE_W*r_cnt[BSEL_W-1:0] +: BYTE_W];
                                n_cnt    = r_cnt + CNT_W'(1);
                            end
                        end else if (r_cmd == r_wr_op) begin
                            s_req.wr_en = 1'b1;
                            n_cmd       = '0;
                            n_cnt       = '0;
                            n_phase     = PH_CMD;
                        end
                    end
                    default: begin
                        n_phase = PH_CMD;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CMD;
            r_cmd   <= '0;
            r_addr  <= '0;
            r_cnt   <= '0;
            r_cap   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_addr  <= n_addr;
            r_cnt   <= n_cnt;
            r_cap   <= n_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s_in_acc) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    // result payload, loaded together with the store read
    always_ff @(posedge i_clk) begin
        if (s_in_acc) begin
            r_o_load <= n_o_load;
            r_o_mem  <= n_o_mem;
            r_o_byte <= n_o_byte;
        end
    end

    spi_sra_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (s_req),
        .o_rd_data (s_rd_data)
    );

    assign o_m_tvalid = r_o_valid;
    assign o_m_tuser  = r_o_load;
    assign o_m_tdata  = r_o_mem ? s_rd_data : r_o_byte;

    // no byte is ever sent without tx_load
    a_idle_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("result without tx_load carries a nonzero byte");

    // byte count stays within the captured word
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(VALUE_BYTES))
        else $error("byte count beyond captured word");

    // deselect returns to command phase with the command cleared
    a_deselect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_in_acc && s_kind == KIND_DESELECT) |=>
        (r_phase == PH_CMD && r_cmd == '0 && r_cnt == '0))
        else $error("deselect did not clear transfer state");

    // store-sourced results are always loads
    a_mem_is_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_o_mem) |-> o_m_tuser)
        else $error("store read result without tx_load");

    // one store access per item
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_req.rd_en && s_req.wr_en))
        else $error("store read and write issued together");

endmodule
`default_nettype wire
